### hw/rtl/sci_pkg.sv
// Shared types, widths and arithmetic steps of the segment/circle crossing unit.
`timescale 1ns / 1ps

package sci_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int RAD_BITS   = 10;

  // Derived widths
  localparam int R2_W     = 2 * RAD_BITS;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int L2_W     = 2 * COORD_BITS + 1;
  localparam int DOT_W    = SQ_W + 1;
  localparam int XMAG_W   = COORD_BITS + 11;
  localparam int XSQ_W    = 2 * XMAG_W;
  localparam int DS_W     = XSQ_W + 1;
  localparam int DISC_W   = R2_W + L2_W;
  localparam int G_W      = (DISC_W + 2 * FRAC_BITS + 1) / 2;
  localparam int SQ_REM_W = G_W + 3;
  localparam int TOL_W    = (L2_W + 1) / 2;
  localparam int TREM_W   = TOL_W + 3;
  localparam int QW       = COORD_BITS + 2;
  localparam int N_W      = L2_W + FRAC_BITS + 1;
  localparam int NS_W     = DOT_W + FRAC_BITS + 2;
  localparam int DREM_W   = L2_W + 1;
  localparam int PR_W     = QW + 1 + DIFF_W;
  localparam int CW       = PR_W + 2;

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
  } in_t;

  typedef struct packed {
    logic                  hit;
    logic                  first_valid;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic                  second_valid;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
  } out_t;

  // Front end result: discriminant and segment terms
  typedef struct packed {
    logic                     hit;
    logic [DISC_W-1:0]        disc;
    logic [L2_W-1:0]          l2;
    logic signed [DOT_W-1:0]  dot;
    logic [COORD_BITS-1:0]    sx;
    logic [COORD_BITS-1:0]    sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } prep_t;

  // Square root result
  typedef struct packed {
    logic                     hit;
    logic [G_W-1:0]           g;
    logic [TOL_W-1:0]         tol;
    logic [L2_W-1:0]          l2;
    logic signed [DOT_W-1:0]  dot;
    logic [COORD_BITS-1:0]    sx;
    logic [COORD_BITS-1:0]    sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } root_t;

  // Segment parameters of both crossings
  typedef struct packed {
    logic                     hit;
    logic                     first_valid;
    logic                     second_valid;
    logic [QW-1:0]            u1;
    logic [QW-1:0]            u2;
    logic [COORD_BITS-1:0]    sx;
    logic [COORD_BITS-1:0]    sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } quo_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [G_W-1:0]      root;
  } sq_step_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic              qbit;
  } div_step_t;

  // One digit of a restoring square root: bring down two radicand bits
  function automatic sq_step_t sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                         input logic [G_W-1:0] root,
                                         input logic [1:0] pair);
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    sq_step_t            res;
    cur   = {rem[SQ_REM_W-3:0], pair};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {root[G_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {root[G_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of a restoring division: bring down one dividend bit
  function automatic div_step_t div_step(input logic [DREM_W-1:0] rem,
                                         input logic [L2_W-1:0] dsr,
                                         input logic din);
    logic [DREM_W-1:0] cur;
    div_step_t         res;
    cur = {rem[DREM_W-2:0], din};
    if (cur >= {1'b0, dsr}) begin
      res.rem  = cur - {1'b0, dsr};
      res.qbit = 1'b1;
    end else begin
      res.rem  = cur;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

### hw/rtl/sci_prep.sv
// Front end: differences, products, inside, degenerate and range checks, discriminant.
`timescale 1ns / 1ps

module sci_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sci_pkg::R2_W-1:0]   r2_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  sci_pkg::in_t               data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output sci_pkg::prep_t             data_o
);
  import sci_pkg::*;

  localparam int NST = 5;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vin;
  logic [NST-1:0] en;
  logic [NST:0]   rdy;

  // Stage 0: coordinate differences
  logic [COORD_BITS-1:0]    s0_sx_q, s0_sy_q;
  logic signed [DIFF_W-1:0] s0_dx_q, s0_dy_q, s0_vx_q, s0_vy_q, s0_wx_q, s0_wy_q;
  // Stage 1: products
  logic [COORD_BITS-1:0]    s1_sx_q, s1_sy_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q;
  logic signed [SQ_W-1:0]   s1_dxx_q, s1_dyy_q, s1_vxdy_q, s1_vydx_q, s1_vxdx_q, s1_vydy_q;
  logic signed [SQ_W-1:0]   s1_vxx_q, s1_vyy_q, s1_wxx_q, s1_wyy_q;
  // Stage 2: sums and checks
  logic signed [DOT_W-1:0]  l2_sum, xprod, dot, ds, de, xmag;
  logic                     both_in, far;
  logic [COORD_BITS-1:0]    s2_sx_q, s2_sy_q;
  logic signed [DIFF_W-1:0] s2_dx_q, s2_dy_q;
  logic [L2_W-1:0]          s2_l2_q;
  logic signed [DOT_W-1:0]  s2_dot_q;
  logic [XMAG_W-1:0]        s2_xm_q;
  logic                     s2_ok_q;
  // Stage 3: wide products
  logic [COORD_BITS-1:0]    s3_sx_q, s3_sy_q;
  logic signed [DIFF_W-1:0] s3_dx_q, s3_dy_q;
  logic [L2_W-1:0]          s3_l2_q;
  logic signed [DOT_W-1:0]  s3_dot_q;
  logic [DISC_W-1:0]        s3_r2l2_q;
  logic [XSQ_W-1:0]         s3_xsq_q;
  logic                     s3_ok_q;
  // Stage 4: discriminant
  logic signed [DS_W-1:0]   dsig;
  prep_t                    s4_q;

  // Stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[NST] = ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vin = {vld_q[NST-2:0], valid_i};
  assign en  = vin & rdy[NST-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // Sums, cross product and range checks
  always_comb begin
    l2_sum  = DOT_W'(s1_dxx_q) + DOT_W'(s1_dyy_q);
    xprod   = DOT_W'(s1_vxdy_q) - DOT_W'(s1_vydx_q);
    dot     = DOT_W'(s1_vxdx_q) + DOT_W'(s1_vydy_q);
    ds      = DOT_W'(s1_vxx_q) + DOT_W'(s1_vyy_q);
    de      = DOT_W'(s1_wxx_q) + DOT_W'(s1_wyy_q);
    xmag    = xprod[DOT_W-1] ? -xprod : xprod;
    both_in = (ds < $signed(DOT_W'(r2_i))) && (de < $signed(DOT_W'(r2_i)));
    far     = |xmag[DOT_W-1:XMAG_W];
  end

  assign dsig = $signed({2'b00, s3_r2l2_q}) - $signed({1'b0, s3_xsq_q});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_sx_q <= data_i.start_x;
      s0_sy_q <= data_i.start_y;
      s0_dx_q <= $signed({1'b0, data_i.end_x}) - $signed({1'b0, data_i.start_x});
      s0_dy_q <= $signed({1'b0, data_i.end_y}) - $signed({1'b0, data_i.start_y});
      s0_vx_q <= $signed({1'b0, data_i.center_x}) - $signed({1'b0, data_i.start_x});
      s0_vy_q <= $signed({1'b0, data_i.center_y}) - $signed({1'b0, data_i.start_y});
      s0_wx_q <= $signed({1'b0, data_i.end_x}) - $signed({1'b0, data_i.center_x});
      s0_wy_q <= $signed({1'b0, data_i.end_y}) - $signed({1'b0, data_i.center_y});
    end
    if (en[1]) begin
      s1_sx_q   <= s0_sx_q;
      s1_sy_q   <= s0_sy_q;
      s1_dx_q   <= s0_dx_q;
      s1_dy_q   <= s0_dy_q;
      s1_dxx_q  <= SQ_W'(s0_dx_q) * SQ_W'(s0_dx_q);
      s1_dyy_q  <= SQ_W'(s0_dy_q) * SQ_W'(s0_dy_q);
      s1_vxdy_q <= SQ_W'(s0_vx_q) * SQ_W'(s0_dy_q);
      s1_vydx_q <= SQ_W'(s0_vy_q) * SQ_W'(s0_dx_q);
      s1_vxdx_q <= SQ_W'(s0_vx_q) * SQ_W'(s0_dx_q);
      s1_vydy_q <= SQ_W'(s0_vy_q) * SQ_W'(s0_dy_q);
      s1_vxx_q  <= SQ_W'(s0_vx_q) * SQ_W'(s0_vx_q);
      s1_vyy_q  <= SQ_W'(s0_vy_q) * SQ_W'(s0_vy_q);
      s1_wxx_q  <= SQ_W'(s0_wx_q) * SQ_W'(s0_wx_q);
      s1_wyy_q  <= SQ_W'(s0_wy_q) * SQ_W'(s0_wy_q);
    end
    if (en[2]) begin
      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_dx_q  <= s1_dx_q;
      s2_dy_q  <= s1_dy_q;
      s2_l2_q  <= l2_sum[L2_W-1:0];
      s2_dot_q <= dot;
      s2_xm_q  <= xmag[XMAG_W-1:0];
      s2_ok_q  <= !both_in && (l2_sum != '0) && !far;
    end
    if (en[3]) begin
      s3_sx_q   <= s2_sx_q;
      s3_sy_q   <= s2_sy_q;
      s3_dx_q   <= s2_dx_q;
      s3_dy_q   <= s2_dy_q;
      s3_l2_q   <= s2_l2_q;
      s3_dot_q  <= s2_dot_q;
      s3_r2l2_q <= DISC_W'(r2_i) * DISC_W'(s2_l2_q);
      s3_xsq_q  <= XSQ_W'(s2_xm_q) * XSQ_W'(s2_xm_q);
      s3_ok_q   <= s2_ok_q;
    end
    if (en[4]) begin
      s4_q.hit  <= s3_ok_q && !dsig[DS_W-1];
      s4_q.disc <= dsig[DISC_W-1:0];
      s4_q.l2   <= s3_l2_q;
      s4_q.dot  <= s3_dot_q;
      s4_q.sx   <= s3_sx_q;
      s4_q.sy   <= s3_sy_q;
      s4_q.dx   <= s3_dx_q;
      s4_q.dy   <= s3_dy_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NST-1];
  assign data_o  = s4_q;

endmodule

### hw/rtl/sci_root.sv
// Pipelined square roots: discriminant root in Q.F and integer root of the length.
`timescale 1ns / 1ps

module sci_root (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sci_pkg::prep_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sci_pkg::root_t   data_o
);
  import sci_pkg::*;

  typedef struct packed {
    prep_t               p;
    logic [SQ_REM_W-1:0] rem;
    logic [G_W-1:0]      root;
    logic [TREM_W-1:0]   trem;
    logic [TOL_W-1:0]    troot;
  } rt_st_t;

  rt_st_t st_q  [G_W];
  rt_st_t st_in [G_W];
  rt_st_t st_nx [G_W];

  logic [G_W-1:0] vld_q;
  logic [G_W-1:0] vin;
  logic [G_W-1:0] en;
  logic [G_W:0]   rdy;

  always_comb begin
    rdy[G_W] = ready_i;
    for (int k = G_W - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vin = {vld_q[G_W-2:0], valid_i};
  assign en  = vin & rdy[G_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < G_W; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // One root digit per stage; the length root runs in the first stages
  for (genvar s = 0; s < G_W; s++) begin : g_stage
    logic [2*G_W-1:0] grad;
    sq_step_t         gs;

    if (s == 0) begin : g_first
      assign st_in[s] = {data_i, {(SQ_REM_W + G_W + TREM_W + TOL_W){1'b0}}};
    end else begin : g_next
      assign st_in[s] = st_q[s-1];
    end

    assign grad = {{(2*G_W - DISC_W - 2*FRAC_BITS){1'b0}}, st_in[s].p.disc,
                   {(2*FRAC_BITS){1'b0}}};
    assign gs   = sqrt_step(st_in[s].rem, st_in[s].root, grad[2*(G_W-1-s) +: 2]);

    if (s < TOL_W) begin : g_tol
      logic [2*TOL_W-1:0] trad;
      sq_step_t           ts;
      assign trad = {{(2*TOL_W - L2_W){1'b0}}, st_in[s].p.l2};
      assign ts   = sqrt_step(SQ_REM_W'(st_in[s].trem), G_W'(st_in[s].troot),
                              trad[2*(TOL_W-1-s) +: 2]);
      always_comb begin
        st_nx[s]       = st_in[s];
        st_nx[s].rem   = gs.rem;
        st_nx[s].root  = gs.root;
        st_nx[s].trem  = ts.rem[TREM_W-1:0];
        st_nx[s].troot = ts.root[TOL_W-1:0];
      end
    end else begin : g_hold
      always_comb begin
        st_nx[s]      = st_in[s];
        st_nx[s].rem  = gs.rem;
        st_nx[s].root = gs.root;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < G_W; k++) begin
      if (en[k]) begin
        st_q[k] <= st_nx[k];
      end
    end
  end

  always_comb begin
    data_o.hit = st_q[G_W-1].p.hit;
    data_o.g   = st_q[G_W-1].root;
    data_o.tol = st_q[G_W-1].troot;
    data_o.l2  = st_q[G_W-1].p.l2;
    data_o.dot = st_q[G_W-1].p.dot;
    data_o.sx  = st_q[G_W-1].p.sx;
    data_o.sy  = st_q[G_W-1].p.sy;
    data_o.dx  = st_q[G_W-1].p.dx;
    data_o.dy  = st_q[G_W-1].p.dy;
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[G_W-1];

endmodule

### hw/rtl/sci_div.sv
// Crossing numerators, on-segment tests and pipelined division by the squared length.
`timescale 1ns / 1ps

module sci_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sci_pkg::root_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sci_pkg::quo_t    data_o
);
  import sci_pkg::*;

  localparam int NST = QW + 2;

  typedef struct packed {
    logic                     hit;
    logic signed [NS_W-1:0]   n1;
    logic signed [NS_W-1:0]   n2;
    logic signed [NS_W-1:0]   hi;
    logic [TOL_W-1:0]         tol;
    logic [L2_W-1:0]          l2;
    logic [COORD_BITS-1:0]    sx;
    logic [COORD_BITS-1:0]    sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } num_t;

  typedef struct packed {
    logic                     hit;
    logic                     v1;
    logic                     v2;
    logic [DREM_W-1:0]        r1;
    logic [DREM_W-1:0]        r2;
    logic [QW-1:0]            lo1;
    logic [QW-1:0]            lo2;
    logic [QW-1:0]            q1;
    logic [QW-1:0]            q2;
    logic [L2_W-1:0]          l2;
    logic [COORD_BITS-1:0]    sx;
    logic [COORD_BITS-1:0]    sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } dv_st_t;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vin;
  logic [NST-1:0] en;
  logic [NST:0]   rdy;

  num_t   a_q;
  num_t   a_d;
  dv_st_t dv_q  [QW+1];
  dv_st_t dv_nx [QW+1];

  logic signed [NS_W-1:0] dotq, gq, ntol;
  logic                   v1, v2;
  logic [N_W-1:0]         num1, num2;

  always_comb begin
    rdy[NST] = ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vin = {vld_q[NST-2:0], valid_i};
  assign en  = vin & rdy[NST-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // Numerators of both crossings and the upper bound
  always_comb begin
    dotq    = NS_W'($signed(data_i.dot)) <<< FRAC_BITS;
    gq      = $signed(NS_W'(data_i.g));
    a_d.hit = data_i.hit;
    a_d.n1  = dotq - gq;
    a_d.n2  = dotq + gq;
    a_d.hi  = $signed(NS_W'({data_i.l2, {FRAC_BITS{1'b0}}})) + $signed(NS_W'(data_i.tol));
    a_d.tol = data_i.tol;
    a_d.l2  = data_i.l2;
    a_d.sx  = data_i.sx;
    a_d.sy  = data_i.sy;
    a_d.dx  = data_i.dx;
    a_d.dy  = data_i.dy;
  end

  // On-segment tests; a slightly negative numerator divides to zero
  always_comb begin
    ntol = -$signed(NS_W'(a_q.tol));
    v1   = a_q.hit && ($signed(a_q.n1) > ntol) && ($signed(a_q.n1) < $signed(a_q.hi));
    v2   = a_q.hit && ($signed(a_q.n2) > ntol) && ($signed(a_q.n2) < $signed(a_q.hi));
    num1 = (v1 && !a_q.n1[NS_W-1]) ? a_q.n1[N_W-1:0] : '0;
    num2 = (v2 && !a_q.n2[NS_W-1]) ? a_q.n2[N_W-1:0] : '0;

    dv_nx[0].hit = a_q.hit;
    dv_nx[0].v1  = v1;
    dv_nx[0].v2  = v2;
    dv_nx[0].r1  = DREM_W'(num1[N_W-1:QW]);
    dv_nx[0].r2  = DREM_W'(num2[N_W-1:QW]);
    dv_nx[0].lo1 = num1[QW-1:0];
    dv_nx[0].lo2 = num2[QW-1:0];
    dv_nx[0].q1  = '0;
    dv_nx[0].q2  = '0;
    dv_nx[0].l2  = a_q.l2;
    dv_nx[0].sx  = a_q.sx;
    dv_nx[0].sy  = a_q.sy;
    dv_nx[0].dx  = a_q.dx;
    dv_nx[0].dy  = a_q.dy;
  end

  // One quotient bit per stage for each crossing
  for (genvar s = 0; s < QW; s++) begin : g_stage
    div_step_t d1, d2;
    assign d1 = div_step(dv_q[s].r1, dv_q[s].l2, dv_q[s].lo1[QW-1-s]);
    assign d2 = div_step(dv_q[s].r2, dv_q[s].l2, dv_q[s].lo2[QW-1-s]);
    always_comb begin
      dv_nx[s+1]    = dv_q[s];
      dv_nx[s+1].r1 = d1.rem;
      dv_nx[s+1].r2 = d2.rem;
      dv_nx[s+1].q1 = {dv_q[s].q1[QW-2:0], d1.qbit};
      dv_nx[s+1].q2 = {dv_q[s].q2[QW-2:0], d2.qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q <= a_d;
    end
    for (int k = 0; k <= QW; k++) begin
      if (en[k+1]) begin
        dv_q[k] <= dv_nx[k];
      end
    end
  end

  always_comb begin
    data_o.hit          = dv_q[QW].hit;
    data_o.first_valid  = dv_q[QW].v1;
    data_o.second_valid = dv_q[QW].v2;
    data_o.u1           = dv_q[QW].q1;
    data_o.u2           = dv_q[QW].q2;
    data_o.sx           = dv_q[QW].sx;
    data_o.sy           = dv_q[QW].sy;
    data_o.dx           = dv_q[QW].dx;
    data_o.dy           = dv_q[QW].dy;
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NST-1];

endmodule

### hw/rtl/sci_post.sv
// Back end: crossing coordinates from segment parameters, clamping, result register.
`timescale 1ns / 1ps

module sci_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sci_pkg::quo_t    data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sci_pkg::out_t    data_o
);
  import sci_pkg::*;

  localparam int NST = 2;

  typedef struct packed {
    logic                   hit;
    logic                   v1;
    logic                   v2;
    logic signed [PR_W-1:0] p1x;
    logic signed [PR_W-1:0] p1y;
    logic signed [PR_W-1:0] p2x;
    logic signed [PR_W-1:0] p2y;
    logic [COORD_BITS-1:0]  sx;
    logic [COORD_BITS-1:0]  sy;
  } mul_t;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vin;
  logic [NST-1:0] en;
  logic [NST:0]   rdy;

  mul_t x_q;
  out_t res_q;

  // Start point in Q.F plus offset, truncated and clamped to the grid
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [COORD_BITS-1:0] base,
                                                     input logic signed [PR_W-1:0] off);
    logic signed [CW-1:0]  c;
    logic [COORD_BITS-1:0] r;
    c = $signed(CW'({base, {FRAC_BITS{1'b0}}})) + CW'(off);
    if (c[CW-1]) begin
      r = '0;
    end else if (|c[CW-2:COORD_BITS+FRAC_BITS]) begin
      r = COORD_MAX;
    end else begin
      r = c[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
    end
    return r;
  endfunction

  always_comb begin
    rdy[NST] = ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vin = {vld_q[NST-2:0], valid_i};
  assign en  = vin & rdy[NST-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Scale the direction by each parameter
    if (en[0]) begin
      x_q.hit <= data_i.hit;
      x_q.v1  <= data_i.first_valid;
      x_q.v2  <= data_i.second_valid;
      x_q.p1x <= PR_W'($signed({1'b0, data_i.u1})) * PR_W'($signed(data_i.dx));
      x_q.p1y <= PR_W'($signed({1'b0, data_i.u1})) * PR_W'($signed(data_i.dy));
      x_q.p2x <= PR_W'($signed({1'b0, data_i.u2})) * PR_W'($signed(data_i.dx));
      x_q.p2y <= PR_W'($signed({1'b0, data_i.u2})) * PR_W'($signed(data_i.dy));
      x_q.sx  <= data_i.sx;
      x_q.sy  <= data_i.sy;
    end
    // Form the result; absent crossings read all ones
    if (en[1]) begin
      res_q.hit          <= x_q.hit;
      res_q.first_valid  <= x_q.v1;
      res_q.first_x      <= x_q.v1 ? to_coord(x_q.sx, x_q.p1x) : COORD_MAX;
      res_q.first_y      <= x_q.v1 ? to_coord(x_q.sy, x_q.p1y) : COORD_MAX;
      res_q.second_valid <= x_q.v2;
      res_q.second_x     <= x_q.v2 ? to_coord(x_q.sx, x_q.p2x) : COORD_MAX;
      res_q.second_y     <= x_q.v2 ? to_coord(x_q.sy, x_q.p2y) : COORD_MAX;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NST-1];
  assign data_o  = res_q;

endmodule

### hw/rtl/segment_circle_intersection.sv
// Top level of the segment/circle crossing unit.
// Takes one segment and circle centre per transaction and returns whether the
// segment's line meets the circle of radius sight_radius (no hit when both ends
// lie inside), plus the nearer and farther crossings that lie on the segment,
// truncated to grid coordinates (65535 when absent). One transaction is accepted
// every cycle when the output is not stalled, and each transaction passes through
// 5 front-end stages, 43 square-root stages (one root digit per stage of the
// discriminant root sets this length), 20 division stages and 2 back-end
// stages. Each stage advances when it is empty or its successor advances, so
// a stalled output only backs up the pipeline once its bubbles are filled.
// Write sight_radius only while no transaction is in flight.
`timescale 1ns / 1ps

module segment_circle_intersection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sci_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sci_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sci_pkg::RAD_BITS-1:0]  cfg_data_i
);
  import sci_pkg::*;

  logic [R2_W-1:0] r2_q;
  logic            prep_ready, prep_valid;
  logic            root_ready, root_valid;
  logic            div_ready, div_valid;
  logic            post_ready;
  prep_t           prep_data;
  root_t           root_data;
  quo_t            div_data;

  // Hold the squared radius
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      r2_q <= R2_W'(cfg_data_i) * R2_W'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !prep_ready;

  sci_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .r2_i    (r2_q),
    .valid_i (in_valid_i),
    .ready_o (prep_ready),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .ready_i (root_ready),
    .data_o  (prep_data)
  );

  sci_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (root_ready),
    .data_i  (prep_data),
    .valid_o (root_valid),
    .ready_i (div_ready),
    .data_o  (root_data)
  );

  sci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_valid),
    .ready_o (div_ready),
    .data_i  (root_data),
    .valid_o (div_valid),
    .ready_i (post_ready),
    .data_o  (div_data)
  );

  sci_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (post_ready),
    .data_i  (div_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_data_o)
  );

  // A crossing is only reported on a hit
  a_flags_need_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hit ||
                     (!out_data_o.first_valid && !out_data_o.second_valid)))
    else $error("crossing reported without hit");

  a_first_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.first_valid) |->
      (out_data_o.first_x == COORD_MAX && out_data_o.first_y == COORD_MAX))
    else $error("absent first crossing not all ones");

  a_second_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.second_valid) |->
      (out_data_o.second_x == COORD_MAX && out_data_o.second_y == COORD_MAX))
    else $error("absent second crossing not all ones");

endmodule

### sim/testbench.sv
// Self-checking testbench for the segment/circle crossing unit.
`timescale 1ns / 1ps

module testbench;
  import sci_pkg::*;

  localparam int          LATENCY     = 70;
  localparam int          LONG_HOLD   = 300;
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam longint      ONE_Q       = 64'sd1 << FRAC_BITS;
  localparam longint      EPS_Q       = ((64'sd1 << FRAC_BITS) + 99999) / 100000;
  localparam longint      CROSS_LIM   = 64'sd1 << (COORD_BITS + 11);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [RAD_BITS-1:0] cfg_data_i;

  segment_circle_intersection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  in_t                 segment_q[$];
  out_t                crossing_q[$];
  logic [RAD_BITS-1:0] radius;
  int                  errors = 0;
  int                  send_gap;
  int                  recv_gap;
  int                  hold_cnt;
  bit                  quiet;
  bit                  long_req;
  bit                  long_taken;
  longint              cycles = 0;

  // floor(sqrt(v)) of a 128-bit radicand, two bits per digit
  function automatic longint unsigned int_sqrt(logic [127:0] v);
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  root;
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = {rem[125:0], v[2*i +: 2]};
      trial = {62'd0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [COORD_BITS-1:0] grid_coord(longint q);
    longint c;
    if (q < 0) return '0;
    c = q >>> FRAC_BITS;
    return (c > longint'(COORD_MAX)) ? COORD_MAX : c[COORD_BITS-1:0];
  endfunction

  // Expected crossings of one segment against the current circle
  function automatic out_t predict_crossings(in_t s, logic [RAD_BITS-1:0] rad);
    out_t   o;
    longint sx, sy, ex, ey, cx, cy, r2, dx, dy, l2, vx, vy, cr, disc, g, tol, dotq, hi, n, u;
    sx = longint'(s.start_x);  sy = longint'(s.start_y);
    ex = longint'(s.end_x);    ey = longint'(s.end_y);
    cx = longint'(s.center_x); cy = longint'(s.center_y);
    r2 = longint'(rad) * longint'(rad);
    o = '{hit: 1'b0, first_valid: 1'b0, first_x: COORD_MAX, first_y: COORD_MAX,
          second_valid: 1'b0, second_x: COORD_MAX, second_y: COORD_MAX};
    if ((sx-cx)*(sx-cx) + (sy-cy)*(sy-cy) < r2 && (ex-cx)*(ex-cx) + (ey-cy)*(ey-cy) < r2)
      return o;
    dx = ex - sx;
    dy = ey - sy;
    l2 = dx*dx + dy*dy;
    if (l2 == 0) return o;
    vx = cx - sx;
    vy = cy - sy;
    cr = vx*dy - vy*dx;
    if ((cr < 0 ? -cr : cr) >= CROSS_LIM) return o;
    disc = r2*l2 - cr*cr;
    if (disc < 0) return o;
    o.hit = 1'b1;
    g    = int_sqrt({64'd0, disc} << (2*FRAC_BITS));
    tol  = (EPS_Q * longint'(int_sqrt({64'd0, l2} << (2*FRAC_BITS)))) >>> FRAC_BITS;
    dotq = (vx*dx + vy*dy) * ONE_Q;
    hi   = l2*ONE_Q + tol;
    n = dotq - g;
    if (n > -tol && n < hi) begin
      u = n / l2;
      o.first_valid = 1'b1;
      o.first_x = grid_coord(sx*ONE_Q + u*dx);
      o.first_y = grid_coord(sy*ONE_Q + u*dy);
    end
    n = dotq + g;
    if (n > -tol && n < hi) begin
      u = n / l2;
      o.second_valid = 1'b1;
      o.second_x = grid_coord(sx*ONE_Q + u*dx);
      o.second_y = grid_coord(sy*ONE_Q + u*dy);
    end
    return o;
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(int c, int span);
    int v;
    v = c + $urandom_range(2*span, 0) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[COORD_BITS-1:0];
  endfunction

  // Mostly segments placed around the circle, some pure noise
  function automatic in_t random_segment(int rad);
    in_t s;
    int  span;
    s = in_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(9, 0) < 8) begin
      span = 2*rad + 4;
      if ($urandom_range(4, 0) == 0) begin
        s.center_x = $urandom_range(1, 0) ? 16'($urandom_range(rad, 0))
                                          : 16'(65535 - $urandom_range(rad, 0));
        s.center_y = $urandom_range(1, 0) ? 16'($urandom_range(rad, 0))
                                          : 16'(65535 - $urandom_range(rad, 0));
      end
      s.start_x = near_coord(int'(s.center_x), span);
      s.start_y = near_coord(int'(s.center_y), span);
      s.end_x   = near_coord(int'(s.center_x), span);
      s.end_y   = near_coord(int'(s.center_y), span);
      if ($urandom_range(7, 0) == 0) begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
    end
    return s;
  endfunction

  function automatic in_t seg(int sx, int sy, int ex, int ey, int cx, int cy);
    return in_t'({16'(sx), 16'(sy), 16'(ex), 16'(ey), 16'(cx), 16'(cy)});
  endfunction

  // Append one segment to the pending queue
  task automatic add_segment(in_t s);
    segment_q = {segment_q, s};
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Configuration channel: track the radius on each write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius <= cfg_data_i;
    end
  end

  // Driver: offer pending segments, predict each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        crossing_q = {crossing_q, predict_crossings(in_data_i, radius)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (segment_q.size() > 0) begin
          in_data_i  <= segment_q.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(5, 0) == 0) send_gap <= $urandom_range(3, 1);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results in order and drive the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    <= 0;
      hold_cnt    <= 0;
      long_taken  <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (crossing_q.size() == 0) begin
          $error("unexpected result %p", out_data_o);
          errors++;
        end else begin
          want = crossing_q.pop_front();
          if (out_data_o.hit !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, out_data_o.hit); errors++;
          end
          if (out_data_o.first_valid !== want.first_valid) begin
            $error("first_valid: expected %0d actual %0d", want.first_valid,
                   out_data_o.first_valid); errors++;
          end
          if (out_data_o.first_x !== want.first_x) begin
            $error("first_x: expected %0d actual %0d", want.first_x, out_data_o.first_x);
            errors++;
          end
          if (out_data_o.first_y !== want.first_y) begin
            $error("first_y: expected %0d actual %0d", want.first_y, out_data_o.first_y);
            errors++;
          end
          if (out_data_o.second_valid !== want.second_valid) begin
            $error("second_valid: expected %0d actual %0d", want.second_valid,
                   out_data_o.second_valid); errors++;
          end
          if (out_data_o.second_x !== want.second_x) begin
            $error("second_x: expected %0d actual %0d", want.second_x, out_data_o.second_x);
            errors++;
          end
          if (out_data_o.second_y !== want.second_y) begin
            $error("second_y: expected %0d actual %0d", want.second_y, out_data_o.second_y);
            errors++;
          end
        end
      end
      if (long_req && !long_taken) begin
        long_taken  <= 1'b1;
        hold_cnt    <= LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(5, 0) == 0) begin
        recv_gap    <= $urandom_range(2, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Wait until everything sent has come back, sampling between edges
  task automatic drain();
    do @(negedge clk_i);
    while (segment_q.size() != 0 || in_valid_i || crossing_q.size() != 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_radius(int rad);
    @(posedge clk_i);
    cfg_data_i  <= rad[RAD_BITS-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int rad, int count);
    set_radius(rad);
    for (int i = 0; i < count; i++) add_segment(random_segment(rad));
    drain();
  endtask

  // Stimulus
  initial begin
    int radii[6];
    quiet       = 1'b0;
    long_req    = 1'b0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and special cases at the full radius, then at zero radius
    set_radius(1023);
    add_segment(seg(0, 0, 0, 0, 0, 0));                   // degenerate segment
    add_segment(seg(65535, 65535, 65535, 65535, 65535, 65535));
    add_segment(seg(0, 0, 65535, 65535, 0, 0));
    add_segment(seg(65535, 0, 0, 65535, 65535, 65535));
    add_segment(seg(1000, 1000, 1010, 1020, 1005, 1005)); // both ends inside
    add_segment(seg(0, 5000, 65535, 5000, 30000, 100));   // line misses
    add_segment(seg(0, 5000, 65535, 5000, 30000, 3977));  // tangent
    add_segment(seg(29000, 5000, 31000, 5000, 30000, 5000));
    add_segment(seg(30000, 5000, 40000, 5000, 30000, 5000)); // one on segment
    add_segment(seg(40000, 5000, 50000, 5000, 30000, 5000)); // both off segment
    add_segment(seg(0, 0, 2000, 0, 0, 0));                // crossing near edge
    add_segment(seg(65535, 0, 63000, 0, 65535, 0));
    add_segment(seg(0, 0, 1023, 0, 0, 0));
    add_segment(seg(1023, 0, 0, 0, 0, 0));
    add_segment(seg(0, 65535, 65535, 0, 32767, 32768));
    add_segment(seg(65535, 65535, 0, 0, 0, 65535));       // far line, large cross
    drain();
    set_radius(0);
    add_segment(seg(0, 0, 100, 0, 50, 0));                // collinear, zero radius
    add_segment(seg(0, 0, 100, 0, 50, 1));
    add_segment(seg(7, 7, 7, 7, 7, 7));
    drain();

    // Random phases; the second one also holds the output off for a long stretch
    radii = '{1023, 37, 1, 500, 0, 255};
    for (int p = 0; p < 6; p++) begin
      if (p == 1) long_req = 1'b1;
      run_random(radii[p], 110);
    end
    run_random($urandom_range(1023, 0), 80);

    // Final part with no idling
    quiet = 1'b1;
    run_random($urandom_range(1023, 2), 100);

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sci_pkg.sv
hw/rtl/sci_prep.sv
hw/rtl/sci_root.sv
hw/rtl/sci_div.sv
hw/rtl/sci_post.sv
hw/rtl/segment_circle_intersection.sv
sim/testbench.sv
